FILE: hdl/rfpd_pkg.sv
// Shared widths, register codes and item types for the radial falloff displacer.
package rfpd_pkg;

    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 31;
    localparam int FRAC_W   = 16;
    localparam int ROOT_W   = 31;
    localparam int QUO_W    = FRAC_W + 1;
    localparam int CFG_IDX_W = 4;
    localparam logic [FRAC_W-1:0] FALLOFF_MAX = {FRAC_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X      = 4'd0,
        REG_CENTER_Y      = 4'd1,
        REG_CENTER_Z      = 4'd2,
        REG_BRUSH_RADIUS  = 4'd3,
        REG_PUSH_X        = 4'd4,
        REG_PUSH_Y        = 4'd5,
        REG_PUSH_Z        = 4'd6,
        REG_PUSH_STRENGTH = 4'd7
    } cfg_idx_t;

    typedef logic [2:0][COORD_W-1:0] point_t;

    typedef struct packed {
        logic   moved;
        point_t point;
    } tag_t;

endpackage

FILE: hdl/rfpd_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a carried tag.
module rfpd_sqrt #(
    parameter int ROOT_W = rfpd_pkg::ROOT_W,
    parameter int TAG_W  = $bits(rfpd_pkg::tag_t)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   in_rad,
    input  logic [TAG_W-1:0]      in_tag,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     out_root,
    output logic [TAG_W-1:0]      out_tag
);

    localparam int REM_W = ROOT_W + 3;

    logic                vld_reg  [0:ROOT_W];
    logic [2*ROOT_W-1:0] rad_reg  [0:ROOT_W];
    logic [REM_W-1:0]    rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0]   root_reg [0:ROOT_W];
    logic [TAG_W-1:0]    tag_reg  [0:ROOT_W];

    logic [2*ROOT_W-1:0] rad_next  [0:ROOT_W-1];
    logic [REM_W-1:0]    rem_next  [0:ROOT_W-1];
    logic [ROOT_W-1:0]   root_next [0:ROOT_W-1];

    always_comb
    begin
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        for (int j = 0; j < ROOT_W; j++)
        begin
            rem_sh = {rem_reg[j][REM_W-3:0], rad_reg[j][2*ROOT_W-1:2*ROOT_W-2]};
            trial  = {1'b0, root_reg[j], 2'b01};
            rad_next[j] = {rad_reg[j][2*ROOT_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next[j]  = rem_sh - trial;
                root_next[j] = {root_reg[j][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[j]  = rem_sh;
                root_next[j] = {root_reg[j][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= ROOT_W; j++)
                vld_reg[j] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int j = 0; j < ROOT_W; j++)
                vld_reg[j+1] <= vld_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg[0]  <= in_rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            tag_reg[0]  <= in_tag;
            for (int j = 0; j < ROOT_W; j++)
            begin
                rad_reg[j+1]  <= rad_next[j];
                rem_reg[j+1]  <= rem_next[j];
                root_reg[j+1] <= root_next[j];
                tag_reg[j+1]  <= tag_reg[j];
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W];
    assign out_root  = root_reg[ROOT_W];
    assign out_tag   = tag_reg[ROOT_W];

endmodule

FILE: hdl/rfpd_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a carried tag.
module rfpd_div #(
    parameter int D_W   = rfpd_pkg::RADIUS_W,
    parameter int Q_W   = rfpd_pkg::QUO_W,
    parameter int TAG_W = $bits(rfpd_pkg::tag_t)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [D_W-1:0]   in_num,
    input  logic [D_W-1:0]   divisor,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [Q_W-1:0]   out_quo,
    output logic [TAG_W-1:0] out_tag
);

    localparam int N_W = D_W + Q_W;

    logic             vld_reg [0:Q_W];
    logic [N_W-1:0]   rem_reg [0:Q_W];
    logic [Q_W-1:0]   quo_reg [0:Q_W];
    logic [TAG_W-1:0] tag_reg [0:Q_W];

    logic [N_W-1:0]   rem_next [0:Q_W-1];
    logic [Q_W-1:0]   quo_next [0:Q_W-1];

    always_comb
    begin
        logic [N_W-1:0] dsh;
        for (int j = 0; j < Q_W; j++)
        begin
            dsh = {{Q_W{1'b0}}, divisor} << (Q_W - 1 - j);
            if (rem_reg[j] >= dsh)
            begin
                rem_next[j] = rem_reg[j] - dsh;
                quo_next[j] = {quo_reg[j][Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[j] = rem_reg[j];
                quo_next[j] = {quo_reg[j][Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= Q_W; j++)
                vld_reg[j] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int j = 0; j < Q_W; j++)
                vld_reg[j+1] <= vld_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {1'b0, in_num, {(Q_W-1){1'b0}}};
            quo_reg[0] <= '0;
            tag_reg[0] <= in_tag;
            for (int j = 0; j < Q_W; j++)
            begin
                rem_reg[j+1] <= rem_next[j];
                quo_reg[j+1] <= quo_next[j];
                tag_reg[j+1] <= tag_reg[j];
            end
        end
    end

    assign out_valid = vld_reg[Q_W];
    assign out_quo   = quo_reg[Q_W];
    assign out_tag   = tag_reg[Q_W];

endmodule

FILE: hdl/radial_falloff_point_displace_top.sv
// Top level of the radial falloff point displacer: config, front end, tail.
// Path from input request to output request: 3 front stages, 32 square root
// stages, 18 divider stages, 3 multiply stages, output register.
// Throughput: one point per cycle; the whole pipeline holds while the output
// register is full and not taken.
// Reset: asynchronous active low; clears valid bits and all config registers.
module radial_falloff_point_displace_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rfpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rfpd_pkg::COORD_W-1:0]   cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [95:0]                    s_axis_tdata,  // in_x, in_y, in_z
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [95:0]                    m_axis_tdata,  // out_x, out_y, out_z
    output logic                           m_axis_tuser   // moved
);

    localparam int CW = rfpd_pkg::COORD_W;
    localparam int RW = rfpd_pkg::RADIUS_W;
    localparam int FW = rfpd_pkg::FRAC_W;
    localparam int TW = $bits(rfpd_pkg::tag_t);

    logic signed [CW-1:0] center_reg [3];
    logic signed [CW-1:0] push_reg [3];
    logic signed [CW-1:0] strength_reg;
    logic [RW-1:0]        radius_reg;
    logic [2*RW-1:0]      rr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                center_reg[i] <= '0;
                push_reg[i]   <= '0;
            end
            strength_reg <= '0;
            radius_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rfpd_pkg::REG_CENTER_X:      center_reg[0] <= cfg_wdata;
                rfpd_pkg::REG_CENTER_Y:      center_reg[1] <= cfg_wdata;
                rfpd_pkg::REG_CENTER_Z:      center_reg[2] <= cfg_wdata;
                rfpd_pkg::REG_BRUSH_RADIUS:  radius_reg    <= cfg_wdata[RW-1:0];
                rfpd_pkg::REG_PUSH_X:        push_reg[0]   <= cfg_wdata;
                rfpd_pkg::REG_PUSH_Y:        push_reg[1]   <= cfg_wdata;
                rfpd_pkg::REG_PUSH_Z:        push_reg[2]   <= cfg_wdata;
                rfpd_pkg::REG_PUSH_STRENGTH: strength_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rr_reg <= radius_reg * radius_reg;
    end

    logic adv;
    logic out_valid_reg;
    assign adv = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // front: difference and magnitude
    logic                s1_valid_reg;
    rfpd_pkg::point_t    s1_point_reg;
    logic [RW-1:0]       s1_abs_reg [3];
    logic                s1_far_reg;
    rfpd_pkg::point_t    in_point;
    logic [RW-1:0]       s1_abs_next [3];
    logic                s1_far_next;

    assign in_point = s_axis_tdata;

    always_comb
    begin
        logic signed [CW:0] diff;
        logic [CW:0]        mag;
        s1_far_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            diff = {in_point[i][CW-1], in_point[i]} - {center_reg[i][CW-1], center_reg[i]};
            mag  = diff[CW] ? (~diff + 1'b1) : diff;
            if (mag[CW:RW] != '0)
                s1_far_next = 1'b1;
            s1_abs_next[i] = mag[RW-1:0];
        end
    end

    // squares
    logic                s2_valid_reg;
    rfpd_pkg::point_t    s2_point_reg;
    logic [2*RW-1:0]     s2_sq_reg [3];
    logic                s2_far_reg;

    // sum
    logic                s3_valid_reg;
    rfpd_pkg::point_t    s3_point_reg;
    logic [63:0]         s3_sum_reg;
    logic                s3_far_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s_axis_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_point_reg <= in_point;
            s1_far_reg   <= s1_far_next;
            for (int i = 0; i < 3; i++)
            begin
                s1_abs_reg[i] <= s1_abs_next[i];
                s2_sq_reg[i]  <= s1_abs_reg[i] * s1_abs_reg[i];
            end
            s2_point_reg <= s1_point_reg;
            s2_far_reg   <= s1_far_reg;
            s3_point_reg <= s2_point_reg;
            s3_far_reg   <= s2_far_reg;
            s3_sum_reg   <= {2'b00, s2_sq_reg[0]} + {2'b00, s2_sq_reg[1]}
                          + {2'b00, s2_sq_reg[2]};
        end
    end

    rfpd_pkg::tag_t sq_tag_in;
    assign sq_tag_in.point = s3_point_reg;
    assign sq_tag_in.moved = !s3_far_reg && (radius_reg != '0)
                           && (s3_sum_reg < {2'b00, rr_reg});

    logic                  sq_valid;
    logic [RW-1:0]         sq_root;
    logic [TW-1:0]         sq_tag;

    rfpd_sqrt #(
        .ROOT_W (rfpd_pkg::ROOT_W),
        .TAG_W  (TW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s3_valid_reg),
        .in_rad    (s3_sum_reg[2*RW-1:0]),
        .in_tag    (sq_tag_in),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    logic                      dv_valid;
    logic [rfpd_pkg::QUO_W-1:0] dv_quo;
    logic [TW-1:0]             dv_tag_bits;
    rfpd_pkg::tag_t            dv_tag;

    rfpd_div #(
        .D_W   (rfpd_pkg::RADIUS_W),
        .Q_W   (rfpd_pkg::QUO_W),
        .TAG_W (TW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sq_valid),
        .in_num    (radius_reg - sq_root),
        .divisor   (radius_reg),
        .in_tag    (sq_tag),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_tag   (dv_tag_bits)
    );

    assign dv_tag = dv_tag_bits;

    // tail: falloff clamp, push scaling, split product, add and saturate
    logic                 m1_valid_reg;
    rfpd_pkg::tag_t       m1_tag_reg;
    logic [FW-1:0]        m1_f_reg;
    logic signed [47:0]   m1_prod_reg [3];

    logic                 m2_valid_reg;
    rfpd_pkg::tag_t       m2_tag_reg;
    logic signed [40:0]   m2_hi_reg [3];
    logic [39:0]          m2_lo_reg [3];

    logic                 m3_valid_reg;
    rfpd_pkg::tag_t       m3_tag_reg;
    logic signed [33:0]   m3_delta_reg [3];

    rfpd_pkg::point_t     out_point_reg;
    logic                 out_moved_reg;

    logic signed [63:0]   full_prod [3];
    logic [65:0]          wide_sum [3];
    rfpd_pkg::point_t     out_point_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            full_prod[i] = push_reg[i] * strength_reg;
            wide_sum[i]  = {m2_hi_reg[i][40], m2_hi_reg[i], 24'b0} + {26'b0, m2_lo_reg[i]};
        end
    end

    always_comb
    begin
        logic signed [CW+2:0] t;
        for (int i = 0; i < 3; i++)
        begin
            t = {{3{m3_tag_reg.point[i][CW-1]}}, m3_tag_reg.point[i]}
              + {m3_delta_reg[i][33], m3_delta_reg[i]};
            if (!m3_tag_reg.moved)
                out_point_next[i] = m3_tag_reg.point[i];
            else if (t[CW+2:CW-1] == '0 || t[CW+2:CW-1] == '1)
                out_point_next[i] = t[CW-1:0];
            else if (t[CW+2])
                out_point_next[i] = {1'b1, {(CW-1){1'b0}}};
            else
                out_point_next[i] = {1'b0, {(CW-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            m3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_valid_reg  <= dv_valid;
            m2_valid_reg  <= m1_valid_reg;
            m3_valid_reg  <= m2_valid_reg;
            out_valid_reg <= m3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_tag_reg <= dv_tag;
            m1_f_reg   <= dv_quo[FW] ? rfpd_pkg::FALLOFF_MAX : dv_quo[FW-1:0];
            m2_tag_reg <= m1_tag_reg;
            m3_tag_reg <= m2_tag_reg;
            for (int i = 0; i < 3; i++)
            begin
                m1_prod_reg[i]  <= full_prod[i][63:16];
                m2_hi_reg[i]    <= $signed(m1_prod_reg[i][47:24]) * $signed({1'b0, m1_f_reg});
                m2_lo_reg[i]    <= m1_prod_reg[i][23:0] * m1_f_reg;
                m3_delta_reg[i] <= wide_sum[i][65:32];
            end
            out_point_reg <= out_point_next;
            out_moved_reg <= m3_tag_reg.moved;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_point_reg;
    assign m_axis_tuser  = out_moved_reg;

endmodule
